@@ hdl/pcoe_pkg.sv @@
// Shared types, constants and register codes for the point cloud overlap extents block.
package pcoe_pkg;

	localparam int COORD_W = 24;
	localparam int EXT_W = 17;
	localparam int RADIUS_W = 48;
	localparam int INVLEN_W = 24;
	localparam int BYTE_W = 8;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 48;
	localparam int QSCALE_W = 24;

	localparam int COORD_FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [EXT_W-1:0] EXT_ONE = 17'd65536;
	localparam logic [INVLEN_W-1:0] INVLEN_RESET = 24'd65536;
	// 255.999 in Q8.16, truncated.
	localparam logic [QSCALE_W-1:0] Q_SCALE = 24'd16777150;

	localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;
	localparam logic [BYTE_W-1:0] WIDEN_STEP = 8'd2;
	localparam logic [BYTE_W-1:0] WIDEN_LO_END = 8'd4;
	localparam logic [BYTE_W-1:0] WIDEN_HI_LIMIT = 8'd253;
	localparam logic [BYTE_W-1:0] WIDEN_HI_BEGIN = 8'd251;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SPHERE_MODE  = 3'd0,
		REG_RADIUS_SQ    = 3'd1,
		REG_INV_LENGTH   = 3'd2,
		REG_SWAP_PAIRS   = 3'd3,
		REG_WIDEN_FIRST  = 3'd4,
		REG_WIDEN_SECOND = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic                sphere_mode;
		logic [RADIUS_W-1:0] radius_sq;
		logic [INVLEN_W-1:0] inv_length;
		logic                swap_pairs;
		logic                widen_first;
		logic                widen_second;
	} cfg_t;

	// Mode write: the target pair reloads with the initial values of the new mode.
	typedef struct packed {
		logic load;
		logic sphere;
	} mode_ld_t;

	// One classified point as it travels from the front to the back.
	typedef struct packed {
		logic             counted;
		logic             tgt_upd;
		logic [EXT_W-1:0] zq;
		logic [EXT_W-1:0] h;
		logic             last;
	} item_t;

endpackage

@@ hdl/pcoe_ifs.sv @@
// Channel interfaces: point input and extents result.
interface pcoe_point_if;
	logic                                valid;
	logic                                ready;
	logic signed [pcoe_pkg::COORD_W-1:0] px;
	logic signed [pcoe_pkg::COORD_W-1:0] py;
	logic signed [pcoe_pkg::COORD_W-1:0] pz;
	logic [pcoe_pkg::EXT_W-1:0]          height_frac;
	logic                                last_point;

	modport source(output valid, px, py, pz, height_frac, last_point, input ready);
	modport sink(input valid, px, py, pz, height_frac, last_point, output ready);
endinterface

interface pcoe_result_if;
	logic                        valid;
	logic                        ready;
	logic                        hit;
	logic [pcoe_pkg::BYTE_W-1:0] ext_a_begin;
	logic [pcoe_pkg::BYTE_W-1:0] ext_a_end;
	logic [pcoe_pkg::BYTE_W-1:0] ext_b_begin;
	logic [pcoe_pkg::BYTE_W-1:0] ext_b_end;

	modport source(output valid, hit, ext_a_begin, ext_a_end, ext_b_begin, ext_b_end,
		input ready);
	modport sink(input valid, hit, ext_a_begin, ext_a_end, ext_b_begin, ext_b_end,
		output ready);
endinterface

@@ hdl/pcoe_front.sv @@
// Front end: squares and z scaling in stage 1, inside test and classification in stage 2.
module pcoe_front #(
	parameter int COORD_FRAC_BITS = pcoe_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	pcoe_point_if.sink           points,
	input  pcoe_pkg::cfg_t       cfg,
	output logic                 item_valid,
	output pcoe_pkg::item_t      item,
	input  logic                 item_ready
);

	localparam int SQ_W = 2 * pcoe_pkg::COORD_W - 1;
	localparam int PROD_W = pcoe_pkg::COORD_W + pcoe_pkg::INVLEN_W;
	localparam int ZSHIFT = 2 * COORD_FRAC_BITS - 16;
	localparam logic [PROD_W:0] ZONE = (PROD_W+1)'(1) << (2 * COORD_FRAC_BITS);

	logic signed [2*pcoe_pkg::COORD_W-1:0] sqx, sqy, sqz;
	logic [pcoe_pkg::COORD_W-1:0]          pz_u;
	logic [PROD_W-1:0]                     prodz;
	logic [pcoe_pkg::EXT_W-1:0]            h_sat;

	logic                       valid_s1;
	logic [SQ_W-1:0]            sx_s1, sy_s1, sz_s1;
	logic [PROD_W-1:0]          prod_s1;
	logic                       nz_s1;
	logic [pcoe_pkg::EXT_W-1:0] h_s1;
	logic                       last_s1;

	logic                       valid_s2;
	pcoe_pkg::item_t            item_s2;

	logic            adv1, adv2;
	logic [SQ_W:0]   r2;
	logic [SQ_W+1:0] r3;
	logic            cyl_in, sph_in, z_ok;
	pcoe_pkg::item_t item_c;

	assign adv2 = !valid_s2 || item_ready;
	assign adv1 = !valid_s1 || adv2;
	assign points.ready = adv1;

	// A negative z only matters through the sign: its product is never used.
	assign sqx = points.px * points.px;
	assign sqy = points.py * points.py;
	assign sqz = points.pz * points.pz;
	assign pz_u = points.pz;
	assign prodz = pz_u * cfg.inv_length;
	assign h_sat = (points.height_frac > pcoe_pkg::EXT_ONE) ? pcoe_pkg::EXT_ONE
		: points.height_frac;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv1)
				valid_s1 <= points.valid;
			if (adv2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && points.valid) begin
			sx_s1 <= sqx[SQ_W-1:0];
			sy_s1 <= sqy[SQ_W-1:0];
			sz_s1 <= sqz[SQ_W-1:0];
			prod_s1 <= prodz;
			nz_s1 <= points.pz[pcoe_pkg::COORD_W-1];
			h_s1 <= h_sat;
			last_s1 <= points.last_point;
		end
		if (adv2 && valid_s1)
			item_s2 <= item_c;
	end

	always_comb begin
		r2 = {1'b0, sx_s1} + {1'b0, sy_s1};
		r3 = {1'b0, r2} + {2'b0, sz_s1};
		cyl_in = {1'b0, r2} <= {1'b0, cfg.radius_sq};
		sph_in = r3 <= {1'b0, cfg.radius_sq};
		// A negative z lies inside only when the length scale is zero.
		z_ok = nz_s1 ? (cfg.inv_length == '0) : ({1'b0, prod_s1} <= ZONE);
		item_c.counted = cfg.sphere_mode ? sph_in : (cyl_in && z_ok);
		item_c.tgt_upd = !cfg.sphere_mode && cyl_in && z_ok;
		item_c.zq = nz_s1 ? '0 : pcoe_pkg::EXT_W'(prod_s1 >> ZSHIFT);
		item_c.h = h_s1;
		item_c.last = last_s1;
	end

	assign item_valid = valid_s2;
	assign item = item_s2;

	a_zq_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && item_s2.tgt_upd |-> item_s2.zq <= pcoe_pkg::EXT_ONE)
		else $error("target height above one on a counted point");

endmodule

@@ hdl/pcoe_queue.sv @@
// Short queue of classified points between the front and the back.
module pcoe_queue #(
	parameter int DEPTH = pcoe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  pcoe_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop,
	output pcoe_pkg::item_t pop_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pcoe_pkg::item_t    mem_q [DEPTH];
	logic [PTR_W-1:0]   wptr_q, rptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid = count_q != '0;
	assign push = push_valid && push_ready;
	assign pop_item = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop)
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= push_item;
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && push_ready |-> count_q < CNT_W'(DEPTH))
		else $error("queue written while full");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue read while empty");

endmodule

@@ hdl/pcoe_back.sv @@
// Back end: extent accumulation, then quantize, swap and widen on the last point.
module pcoe_back (
	input  logic              clk,
	input  logic              arst_n,
	input  pcoe_pkg::cfg_t    cfg,
	input  pcoe_pkg::mode_ld_t mode_ld,
	input  logic              item_valid,
	input  pcoe_pkg::item_t   item,
	output logic              pop,
	pcoe_result_if.source     result
);

	localparam int QPROD_W = pcoe_pkg::EXT_W + pcoe_pkg::QSCALE_W;
	localparam int B = pcoe_pkg::BYTE_W;

	logic                       hit_seen_q;
	logic [pcoe_pkg::EXT_W-1:0] tmin_q, tmax_q, smin_q, smax_q;

	logic                       valid_s1, hit_s1;
	logic [pcoe_pkg::EXT_W-1:0] tmin_s1, tmax_s1, smin_s1, smax_s1;
	logic                       valid_s2, hit_s2;
	logic [B-1:0]               a0_s2, a1_s2, b0_s2, b1_s2;
	logic                       out_valid_q, hit_q;
	logic [B-1:0]               a0_q, a1_q, b0_q, b1_q;

	logic                       adv1, adv2, out_adv;
	logic                       hit_n;
	logic [pcoe_pkg::EXT_W-1:0] tmin_n, tmax_n, smin_n, smax_n;
	logic [QPROD_W-1:0]         qp_tmin, qp_tmax, qp_smin, qp_smax;
	logic [B-1:0]               qt0, qt1, qs0, qs1;
	logic [2*B-1:0]             wa, wb;

	function automatic logic [B-1:0] sat_byte(input logic [QPROD_W-1:0] p);
		logic [QPROD_W-33:0] q;
		begin
			q = p[QPROD_W-1:32];
			return (q > (QPROD_W-32)'(pcoe_pkg::BYTE_MAX)) ? pcoe_pkg::BYTE_MAX : q[B-1:0];
		end
	endfunction

	function automatic logic [2*B-1:0] widen(input logic en, input logic [B-1:0] b,
		input logic [B-1:0] e);
		logic [2*B-1:0] r;
		begin
			r = {b, e};
			if (en && b == e) begin
				if (b < pcoe_pkg::WIDEN_STEP)
					r = {{B{1'b0}}, pcoe_pkg::WIDEN_LO_END};
				else if (e > pcoe_pkg::WIDEN_HI_LIMIT)
					r = {pcoe_pkg::WIDEN_HI_BEGIN, pcoe_pkg::BYTE_MAX};
				else
					r = {b - pcoe_pkg::WIDEN_STEP, e + pcoe_pkg::WIDEN_STEP};
			end
			return r;
		end
	endfunction

	assign out_adv = !out_valid_q || result.ready;
	assign adv2 = !valid_s2 || out_adv;
	assign adv1 = !valid_s1 || adv2;
	// Only a last point waits for room in the result path.
	assign pop = item_valid && (!item.last || adv1);

	always_comb begin
		hit_n = hit_seen_q || item.counted;
		smin_n = (item.counted && item.h < smin_q) ? item.h : smin_q;
		smax_n = (item.counted && item.h > smax_q) ? item.h : smax_q;
		tmin_n = (item.tgt_upd && item.zq < tmin_q) ? item.zq : tmin_q;
		tmax_n = (item.tgt_upd && item.zq > tmax_q) ? item.zq : tmax_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_seen_q <= 1'b0;
			tmin_q <= pcoe_pkg::EXT_ONE;
			tmax_q <= '0;
			smin_q <= pcoe_pkg::EXT_ONE;
			smax_q <= '0;
		end else if (mode_ld.load) begin
			tmin_q <= mode_ld.sphere ? '0 : pcoe_pkg::EXT_ONE;
			tmax_q <= '0;
		end else if (pop) begin
			if (item.last) begin
				hit_seen_q <= 1'b0;
				tmin_q <= cfg.sphere_mode ? '0 : pcoe_pkg::EXT_ONE;
				tmax_q <= '0;
				smin_q <= pcoe_pkg::EXT_ONE;
				smax_q <= '0;
			end else begin
				hit_seen_q <= hit_n;
				tmin_q <= tmin_n;
				tmax_q <= tmax_n;
				smin_q <= smin_n;
				smax_q <= smax_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv1)
				valid_s1 <= pop && item.last;
			if (adv2)
				valid_s2 <= valid_s1;
			if (out_adv)
				out_valid_q <= valid_s2;
		end
	end

	assign qp_tmin = tmin_s1 * pcoe_pkg::Q_SCALE;
	assign qp_tmax = tmax_s1 * pcoe_pkg::Q_SCALE;
	assign qp_smin = smin_s1 * pcoe_pkg::Q_SCALE;
	assign qp_smax = smax_s1 * pcoe_pkg::Q_SCALE;
	assign qt0 = sat_byte(qp_tmin);
	assign qt1 = sat_byte(qp_tmax);
	assign qs0 = sat_byte(qp_smin);
	assign qs1 = sat_byte(qp_smax);
	assign wa = widen(cfg.widen_first, a0_s2, a1_s2);
	assign wb = widen(cfg.widen_second, b0_s2, b1_s2);

	always_ff @(posedge clk) begin
		if (adv1 && pop && item.last) begin
			hit_s1 <= hit_n;
			tmin_s1 <= tmin_n;
			tmax_s1 <= tmax_n;
			smin_s1 <= smin_n;
			smax_s1 <= smax_n;
		end
		if (adv2 && valid_s1) begin
			hit_s2 <= hit_s1;
			a0_s2 <= cfg.swap_pairs ? qs0 : qt0;
			a1_s2 <= cfg.swap_pairs ? qs1 : qt1;
			b0_s2 <= cfg.swap_pairs ? qt0 : qs0;
			b1_s2 <= cfg.swap_pairs ? qt1 : qs1;
		end
		if (out_adv && valid_s2) begin
			hit_q <= hit_s2;
			a0_q <= wa[2*B-1:B];
			a1_q <= wa[B-1:0];
			b0_q <= wb[2*B-1:B];
			b1_q <= wb[B-1:0];
		end
	end

	assign result.valid = out_valid_q;
	assign result.hit = hit_q;
	assign result.ext_a_begin = a0_q;
	assign result.ext_a_end = a1_q;
	assign result.ext_b_begin = b0_q;
	assign result.ext_b_end = b1_q;

	a_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		pop && item.last |=> !hit_seen_q && smin_q == pcoe_pkg::EXT_ONE && smax_q == '0)
		else $error("extents not reinitialized after the last point");

	a_src_order: assert property (@(posedge clk) disable iff (!arst_n)
		hit_seen_q |-> smin_q <= smax_q)
		else $error("source extents out of order after a hit");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv2 |=> valid_s1 && $stable(hit_s1) && $stable(smin_s1))
		else $error("pending result snapshot lost during a stall");

endmodule

@@ hdl/point_cloud_overlap_extents.sv @@
// Top level: configuration registers, front end, queue and back end.
//
//  channel   dir  handshake          payload
//  points    in   valid/ready        px, py, pz, height_frac, last_point
//  result    out  valid/ready        hit, ext_a_begin/end, ext_b_begin/end
//  wr_*      in   wr_en (no wait)    wr_index, wr_data
//
// One point is taken every cycle unless a full queue backs up the front end.
// A point passes the front end (multipliers, then inside test) and then a four-entry queue.
// After its pop, a last point's result passes the snapshot taken at the pop, the quantize
// multipliers and the widening into the output register.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// A stalled result blocks only last points; other points drain into the extents.
module point_cloud_overlap_extents #(
	parameter int COORD_FRAC_BITS = pcoe_pkg::COORD_FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = pcoe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	pcoe_point_if.sink                           points,
	pcoe_result_if.source                        result,
	input  logic                                 wr_en,
	input  logic [pcoe_pkg::CFG_INDEX_W-1:0]     wr_index,
	input  logic [pcoe_pkg::CFG_DATA_W-1:0]      wr_data
);

	pcoe_pkg::cfg_t     cfg_q;
	pcoe_pkg::mode_ld_t mode_ld;
	logic               f_valid, q_ready, q_valid, q_pop;
	pcoe_pkg::item_t    f_item, q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sphere_mode <= 1'b0;
			cfg_q.radius_sq <= '0;
			cfg_q.inv_length <= pcoe_pkg::INVLEN_RESET;
			cfg_q.swap_pairs <= 1'b0;
			cfg_q.widen_first <= 1'b1;
			cfg_q.widen_second <= 1'b1;
		end else if (wr_en) begin
			case (wr_index)
				pcoe_pkg::REG_SPHERE_MODE: cfg_q.sphere_mode <= wr_data[0];
				pcoe_pkg::REG_RADIUS_SQ: cfg_q.radius_sq <= wr_data[pcoe_pkg::RADIUS_W-1:0];
				pcoe_pkg::REG_INV_LENGTH: cfg_q.inv_length <= wr_data[pcoe_pkg::INVLEN_W-1:0];
				pcoe_pkg::REG_SWAP_PAIRS: cfg_q.swap_pairs <= wr_data[0];
				pcoe_pkg::REG_WIDEN_FIRST: cfg_q.widen_first <= wr_data[0];
				pcoe_pkg::REG_WIDEN_SECOND: cfg_q.widen_second <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign mode_ld.load = wr_en && (wr_index == pcoe_pkg::REG_SPHERE_MODE);
	assign mode_ld.sphere = wr_data[0];

	pcoe_front #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.points    (points),
		.cfg       (cfg_q),
		.item_valid(f_valid),
		.item      (f_item),
		.item_ready(q_ready)
	);

	pcoe_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(q_ready),
		.push_item (f_item),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_item  (q_item)
	);

	pcoe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.mode_ld   (mode_ld),
		.item_valid(q_valid),
		.item      (q_item),
		.pop       (q_pop),
		.result    (result)
	);

endmodule

@@ sim/point_cloud_overlap_extents_test.sv @@
// Self-checking testbench for point_cloud_overlap_extents: directed table, random clouds, stalls.
module point_cloud_overlap_extents_test;

	localparam int FRAC_BITS = pcoe_pkg::COORD_FRAC_BITS_DEF;
	localparam int MAX_REPORTS = 10;
	localparam int DRAIN_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 20;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_POINTS = 105;
	localparam int LONG_HOLD = 200;
	localparam longint COORD_TOP = 64'sd8388607;

	localparam logic [pcoe_pkg::CFG_INDEX_W-1:0] UNMAPPED_LO = 3'd6;
	localparam logic [pcoe_pkg::CFG_INDEX_W-1:0] UNMAPPED_HI = 3'd7;
	localparam logic [pcoe_pkg::CFG_DATA_W-1:0] ALL_ONES = 48'hFFFF_FFFF_FFFF;

	localparam logic [pcoe_pkg::COORD_W-1:0] C_ZERO = 24'h000000;
	localparam logic [pcoe_pkg::COORD_W-1:0] C_MAX = 24'h7FFFFF;
	localparam logic [pcoe_pkg::COORD_W-1:0] C_MIN = 24'h800000;
	localparam logic [pcoe_pkg::COORD_W-1:0] C_ONE = 24'h010000;
	localparam logic [pcoe_pkg::COORD_W-1:0] C_NEG1 = 24'hFFFFFF;
	localparam logic [pcoe_pkg::EXT_W-1:0] H_HALF = 17'h08000;
	localparam logic [pcoe_pkg::EXT_W-1:0] H_ONE = 17'h10000;
	localparam logic [pcoe_pkg::EXT_W-1:0] H_TOP = 17'h1FFFF;

	typedef struct packed {
		logic [pcoe_pkg::COORD_W-1:0] px;
		logic [pcoe_pkg::COORD_W-1:0] py;
		logic [pcoe_pkg::COORD_W-1:0] pz;
		logic [pcoe_pkg::EXT_W-1:0]   h;
		logic                         last;
	} point_t;

	typedef struct packed {
		logic                        hit;
		logic [pcoe_pkg::BYTE_W-1:0] a0;
		logic [pcoe_pkg::BYTE_W-1:0] a1;
		logic [pcoe_pkg::BYTE_W-1:0] b0;
		logic [pcoe_pkg::BYTE_W-1:0] b1;
	} extents_t;

	// One directed step: an optional register write, a point, and where it is obvious the result.
	typedef struct packed {
		logic                             wr;
		logic [pcoe_pkg::CFG_INDEX_W-1:0] ridx;
		logic [pcoe_pkg::CFG_DATA_W-1:0]  rval;
		logic [pcoe_pkg::COORD_W-1:0]     px;
		logic [pcoe_pkg::COORD_W-1:0]     py;
		logic [pcoe_pkg::COORD_W-1:0]     pz;
		logic [pcoe_pkg::EXT_W-1:0]       h;
		logic                             last;
		logic                             typed;
		logic                             hit;
		logic [pcoe_pkg::BYTE_W-1:0]      a0;
		logic [pcoe_pkg::BYTE_W-1:0]      a1;
		logic [pcoe_pkg::BYTE_W-1:0]      b0;
		logic [pcoe_pkg::BYTE_W-1:0]      b1;
	} row_t;

	localparam int N_DIRECTED = 22;
	localparam row_t DIRECTED [N_DIRECTED] = '{
		// Reset configuration: unit-length segment with zero radius.
		'{1'b0, UNMAPPED_LO, 48'd0, C_ZERO, C_ZERO, C_ZERO, 17'd0, 1'b1,
		  1'b1, 1'b1, 8'd0, 8'd4, 8'd0, 8'd4},
		'{1'b0, UNMAPPED_LO, 48'd0, C_MAX, C_MAX, C_MAX, H_ONE, 1'b1,
		  1'b1, 1'b0, 8'd255, 8'd0, 8'd255, 8'd0},
		'{1'b0, UNMAPPED_LO, 48'd0, C_MIN, C_MIN, C_MIN, H_TOP, 1'b1,
		  1'b1, 1'b0, 8'd255, 8'd0, 8'd255, 8'd0},
		'{1'b0, UNMAPPED_LO, 48'd0, C_ZERO, C_ZERO, C_ONE, H_TOP, 1'b1,
		  1'b1, 1'b1, 8'd251, 8'd255, 8'd251, 8'd255},
		'{1'b0, UNMAPPED_LO, 48'd0, C_ZERO, C_ZERO, C_NEG1, 17'd100, 1'b1,
		  1'b1, 1'b0, 8'd255, 8'd0, 8'd255, 8'd0},
		'{1'b0, UNMAPPED_LO, 48'd0, C_ZERO, C_ZERO, 24'h010001, 17'd100, 1'b1,
		  1'b1, 1'b0, 8'd255, 8'd0, 8'd255, 8'd0},
		'{1'b0, UNMAPPED_LO, 48'd0, C_ZERO, C_ZERO, 24'h008000, H_HALF, 1'b0,
		  1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{1'b0, UNMAPPED_LO, 48'd0, C_ZERO, C_ZERO, 24'h004000, 17'h04000, 1'b0,
		  1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{1'b0, UNMAPPED_LO, 48'd0, 24'h000001, C_ZERO, C_ZERO, 17'd0, 1'b1,
		  1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{1'b0, UNMAPPED_LO, 48'd0, C_ZERO, C_ZERO, 24'h000200, 17'h00300, 1'b1,
		  1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{1'b0, UNMAPPED_LO, 48'd0, C_ZERO, C_ZERO, 24'h00FD00, 17'h0FC00, 1'b1,
		  1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
		// Writes to unmapped indexes must leave every register alone.
		'{1'b1, UNMAPPED_LO, ALL_ONES, C_ZERO, C_ZERO, C_ZERO, 17'd0, 1'b1,
		  1'b1, 1'b1, 8'd0, 8'd4, 8'd0, 8'd4},
		'{1'b1, UNMAPPED_HI, ALL_ONES, C_ZERO, C_ZERO, C_ZERO, 17'd0, 1'b1,
		  1'b1, 1'b1, 8'd0, 8'd4, 8'd0, 8'd4},
		// Zero inverse length lets a negative z through at height zero.
		'{1'b1, pcoe_pkg::REG_INV_LENGTH, 48'd0, C_ZERO, C_ZERO, C_MIN, 17'h0FFFF, 1'b1,
		  1'b1, 1'b1, 8'd0, 8'd4, 8'd251, 8'd255},
		'{1'b1, pcoe_pkg::REG_SPHERE_MODE, 48'd1, C_ZERO, C_ZERO, C_ZERO, H_HALF, 1'b1,
		  1'b1, 1'b1, 8'd0, 8'd4, 8'd125, 8'd129},
		'{1'b1, pcoe_pkg::REG_RADIUS_SQ, ALL_ONES, C_MIN, C_MIN, C_MIN, 17'd0, 1'b1,
		  1'b1, 1'b1, 8'd0, 8'd4, 8'd0, 8'd4},
		'{1'b1, pcoe_pkg::REG_SWAP_PAIRS, 48'd1, C_MAX, C_ZERO, C_ZERO, H_ONE, 1'b0,
		  1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
		// Mode change inside a cloud: the source pair survives, the target pair reloads.
		'{1'b1, pcoe_pkg::REG_SPHERE_MODE, 48'd0, C_ZERO, C_ZERO, C_ONE, 17'd0, 1'b1,
		  1'b1, 1'b1, 8'd0, 8'd255, 8'd0, 8'd4},
		'{1'b1, pcoe_pkg::REG_WIDEN_FIRST, 48'd0, C_ZERO, C_ZERO, C_ZERO, H_HALF, 1'b1,
		  1'b1, 1'b1, 8'd127, 8'd127, 8'd0, 8'd4},
		'{1'b1, pcoe_pkg::REG_WIDEN_SECOND, 48'd0, C_ZERO, C_ZERO, C_ZERO, H_HALF, 1'b1,
		  1'b1, 1'b1, 8'd127, 8'd127, 8'd0, 8'd0},
		'{1'b1, pcoe_pkg::REG_INV_LENGTH, 48'hFFFFFF, C_ZERO, C_ZERO, 24'h000001, 17'd0,
		  1'b1, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0},
		'{1'b0, UNMAPPED_LO, 48'd0, C_ZERO, C_ZERO, C_NEG1, 17'd5, 1'b1,
		  1'b1, 1'b0, 8'd255, 8'd0, 8'd255, 8'd0}
	};

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             wr_en;
	logic [pcoe_pkg::CFG_INDEX_W-1:0] wr_index;
	logic [pcoe_pkg::CFG_DATA_W-1:0]  wr_data;

	pcoe_point_if points();
	pcoe_result_if result();

	point_cloud_overlap_extents dut (
		.clk(clk),
		.arst_n(arst_n),
		.points(points),
		.result(result),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: register shadow and running extents of the open cloud.
	pcoe_pkg::cfg_t             cfg_model;
	logic                       hit_seen;
	logic [pcoe_pkg::EXT_W-1:0] tgt_min, tgt_max, src_min, src_max;
	extents_t                   pending_q [$];
	extents_t                   seen_result;
	int unsigned                errors = 0;
	int unsigned                missing = 0;
	int unsigned                send_idle_pct = 0;
	int unsigned                rx_stall_pct = 0;
	int unsigned                hold_asked = 0;
	int unsigned                hold_taken = 0;
	int unsigned                hold_left = 0;

	function automatic void clear_extents();
		hit_seen = 1'b0;
		tgt_min = cfg_model.sphere_mode ? '0 : pcoe_pkg::EXT_ONE;
		tgt_max = '0;
		src_min = pcoe_pkg::EXT_ONE;
		src_max = '0;
	endfunction

	function automatic logic [63:0] coord_mag(logic [pcoe_pkg::COORD_W-1:0] c);
		longint v = longint'($signed(c));
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic [pcoe_pkg::BYTE_W-1:0] to_byte(logic [pcoe_pkg::EXT_W-1:0] e);
		logic [63:0] q;
		q = (64'(e) * 64'(pcoe_pkg::Q_SCALE)) >> 32;
		return (q > 64'(pcoe_pkg::BYTE_MAX)) ? pcoe_pkg::BYTE_MAX : q[pcoe_pkg::BYTE_W-1:0];
	endfunction

	function automatic logic [2*pcoe_pkg::BYTE_W-1:0] widen_pair(
			logic [pcoe_pkg::BYTE_W-1:0] b, logic [pcoe_pkg::BYTE_W-1:0] e);
		if (b != e)
			return {b, e};
		if (b < pcoe_pkg::WIDEN_STEP)
			return {8'd0, pcoe_pkg::WIDEN_LO_END};
		if (e > pcoe_pkg::WIDEN_HI_LIMIT)
			return {pcoe_pkg::WIDEN_HI_BEGIN, pcoe_pkg::BYTE_MAX};
		return {b - pcoe_pkg::WIDEN_STEP, e + pcoe_pkg::WIDEN_STEP};
	endfunction

	// Folds one point into the open cloud; on a last point returns 1 with the result.
	function automatic bit accumulate_point(point_t p, output extents_t r);
		logic [63:0]                   mx, my, mz, r2, prod, zq;
		logic [pcoe_pkg::EXT_W-1:0]    h;
		logic [pcoe_pkg::BYTE_W-1:0]   a0, a1, b0, b1;
		logic [2*pcoe_pkg::BYTE_W-1:0] pair;
		bit                            inside_tgt;
		r = '0;
		mx = coord_mag(p.px);
		my = coord_mag(p.py);
		mz = coord_mag(p.pz);
		r2 = mx * mx + my * my;
		h = (p.h > pcoe_pkg::EXT_ONE) ? pcoe_pkg::EXT_ONE : p.h;
		if (cfg_model.sphere_mode) begin
			inside_tgt = (r2 + mz * mz) <= 64'(cfg_model.radius_sq);
		end else begin
			prod = mz * 64'(cfg_model.inv_length);
			inside_tgt = r2 <= 64'(cfg_model.radius_sq)
				&& !(p.pz[pcoe_pkg::COORD_W-1] && prod != 0)
				&& prod <= (64'd1 << (2 * FRAC_BITS));
			if (inside_tgt) begin
				zq = prod >> (2 * FRAC_BITS - 16);
				if (zq[pcoe_pkg::EXT_W-1:0] < tgt_min) tgt_min = zq[pcoe_pkg::EXT_W-1:0];
				if (zq[pcoe_pkg::EXT_W-1:0] > tgt_max) tgt_max = zq[pcoe_pkg::EXT_W-1:0];
			end
		end
		if (inside_tgt) begin
			hit_seen = 1'b1;
			if (h < src_min) src_min = h;
			if (h > src_max) src_max = h;
		end
		if (!p.last)
			return 1'b0;
		a0 = to_byte(tgt_min);
		a1 = to_byte(tgt_max);
		b0 = to_byte(src_min);
		b1 = to_byte(src_max);
		if (cfg_model.swap_pairs) begin
			{a0, a1, b0, b1} = {b0, b1, a0, a1};
		end
		if (cfg_model.widen_first) begin
			pair = widen_pair(a0, a1);
			{a0, a1} = pair;
		end
		if (cfg_model.widen_second) begin
			pair = widen_pair(b0, b1);
			{b0, b1} = pair;
		end
		r = '{hit_seen, a0, a1, b0, b1};
		clear_extents();
		return 1'b1;
	endfunction

	function automatic void note_mismatch(string what, extents_t want, extents_t got);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t %s: expected hit=%0d a=%0d,%0d b=%0d,%0d; got hit=%0d a=%0d,%0d b=%0d,%0d",
				$time, what, want.hit, want.a0, want.a1, want.b0, want.b1,
				got.hit, got.a0, got.a1, got.b0, got.b1);
	endfunction

	task automatic write_reg(logic [pcoe_pkg::CFG_INDEX_W-1:0] idx,
			logic [pcoe_pkg::CFG_DATA_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		case (idx)
			pcoe_pkg::REG_SPHERE_MODE: begin
				cfg_model.sphere_mode = val[0];
				tgt_min = val[0] ? '0 : pcoe_pkg::EXT_ONE;
				tgt_max = '0;
			end
			pcoe_pkg::REG_RADIUS_SQ: cfg_model.radius_sq = val[pcoe_pkg::RADIUS_W-1:0];
			pcoe_pkg::REG_INV_LENGTH: cfg_model.inv_length = val[pcoe_pkg::INVLEN_W-1:0];
			pcoe_pkg::REG_SWAP_PAIRS: cfg_model.swap_pairs = val[0];
			pcoe_pkg::REG_WIDEN_FIRST: cfg_model.widen_first = val[0];
			pcoe_pkg::REG_WIDEN_SECOND: cfg_model.widen_second = val[0];
			default: ;
		endcase
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one point, holds it until the beat is taken, then updates the predictor.
	task automatic send_point(point_t p, bit typed, extents_t want);
		extents_t pred;
		while ($urandom_range(99) < send_idle_pct) begin
			points.valid <= 1'b0;
			@(posedge clk);
		end
		points.valid <= 1'b1;
		points.px <= p.px;
		points.py <= p.py;
		points.pz <= p.pz;
		points.height_frac <= p.h;
		points.last_point <= p.last;
		do
			@(posedge clk);
		while (!points.ready);
		if (accumulate_point(p, pred))
			pending_q.push_back(typed ? want : pred);
	endtask

	// Stops sending, waits for all outstanding results, then lets non-last points drain.
	task automatic wait_idle();
		int unsigned waited;
		waited = 0;
		points.valid <= 1'b0;
		while (pending_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_q.size() != 0) begin
			missing += pending_q.size();
			$display("%0t %0d expected results never arrived", $time, pending_q.size());
			pending_q.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [pcoe_pkg::COORD_W-1:0] rand_coord(longint lo, longint hi);
		longint v;
		case ($urandom_range(19))
			0, 1: return pcoe_pkg::COORD_W'($urandom);
			2: return '0;
			default: ;
		endcase
		v = lo + longint'($urandom_range(0, 32'(hi - lo)));
		return v[pcoe_pkg::COORD_W-1:0];
	endfunction

	function automatic logic [pcoe_pkg::EXT_W-1:0] rand_height();
		case ($urandom_range(9))
			0: return pcoe_pkg::EXT_W'($urandom_range(0, 800));
			1: return pcoe_pkg::EXT_W'($urandom_range(64700, 65536));
			2: return pcoe_pkg::EXT_W'($urandom_range(65537, 131071));
			default: return pcoe_pkg::EXT_W'($urandom_range(0, 65536));
		endcase
	endfunction

	task automatic run_clouds(int unsigned n_points, longint xy_span, longint z_lo,
			longint z_hi, int unsigned last_pct);
		point_t p;
		for (int i = 0; i < n_points; i++) begin
			p.px = rand_coord(-xy_span, xy_span);
			p.py = rand_coord(-xy_span, xy_span);
			p.pz = rand_coord(z_lo, z_hi);
			p.h = rand_height();
			p.last = $urandom_range(99) < last_pct;
			send_point(p, 1'b0, '0);
		end
	endtask

	// Result side: random stalls, long hold-off on request, and the scoreboard check.
	always @(posedge clk) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				seen_result = '{result.hit, result.ext_a_begin, result.ext_a_end,
					result.ext_b_begin, result.ext_b_end};
				if (pending_q.size() == 0) begin
					note_mismatch("unexpected result", '0, seen_result);
				end else if (seen_result.hit !== pending_q[0].hit
						|| seen_result.a0 !== pending_q[0].a0
						|| seen_result.a1 !== pending_q[0].a1
						|| seen_result.b0 !== pending_q[0].b0
						|| seen_result.b1 !== pending_q[0].b1) begin
					note_mismatch("result mismatch", pending_q.pop_front(), seen_result);
				end else begin
					void'(pending_q.pop_front());
				end
			end
			if (hold_taken != hold_asked) begin
				hold_taken = hold_asked;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left = hold_left - 1;
				result.ready <= 1'b0;
			end else begin
				result.ready <= $urandom_range(99) >= rx_stall_pct;
			end
		end
	end

	initial begin
		#3_000_000;
		$display("point_cloud_overlap_extents regression: fail");
		$finish;
	end

	initial begin : main
		row_t        row;
		point_t      p;
		extents_t    want;
		bit          sph, sw, wf, ws;
		longint      r, xy_span, z_lo, z_hi, zlen;
		logic [47:0] rsq;
		logic [23:0] inv;

		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		points.valid = 1'b0;
		points.px = '0;
		points.py = '0;
		points.pz = '0;
		points.height_frac = '0;
		points.last_point = 1'b0;
		cfg_model = '{sphere_mode: 1'b0, radius_sq: '0, inv_length: pcoe_pkg::INVLEN_RESET,
			swap_pairs: 1'b0, widen_first: 1'b1, widen_second: 1'b1};
		clear_extents();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			row = DIRECTED[i];
			if (row.wr) begin
				wait_idle();
				write_reg(row.ridx, row.rval);
			end
			p = '{row.px, row.py, row.pz, row.h, row.last};
			want = '{row.hit, row.a0, row.a1, row.b0, row.b1};
			send_point(p, row.typed, want);
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			r = longint'($urandom_range(256, 1 << 20));
			inv = 24'($urandom_range(1 << 12, 1 << 20));
			sw = 1'b0;
			wf = 1'b1;
			ws = 1'b1;
			case (ph)
				0: begin sph = 1'b0; inv = pcoe_pkg::INVLEN_RESET; end
				1: sph = 1'b1;
				2: begin sph = 1'b0; inv = '0; sw = 1'b1; end
				3: begin sph = 1'b0; r = COORD_TOP; inv = 24'hFFFFFF; wf = 1'b0; end
				4: begin sph = 1'b1; r = COORD_TOP; sw = 1'b1; wf = 1'b0; ws = 1'b0; end
				5: begin sph = 1'b0; r = 0; end
				default: begin
					sph = ph[0];
					sw = 1'($urandom_range(1));
					wf = 1'($urandom_range(1));
					ws = 1'($urandom_range(1));
				end
			endcase
			rsq = (r == COORD_TOP) ? ALL_ONES : 48'(r * r);
			if (r == 0)
				r = 64;
			xy_span = r + r / 4 + 4;
			if (xy_span > COORD_TOP)
				xy_span = COORD_TOP;
			if (sph) begin
				z_lo = -xy_span;
				z_hi = xy_span;
			end else begin
				zlen = (inv == 0) ? COORD_TOP : longint'((64'd1 << 32) / 64'(inv));
				if (zlen > COORD_TOP)
					zlen = COORD_TOP;
				z_lo = -(zlen / 8) - 2;
				z_hi = zlen + zlen / 8 + 2;
				if (z_hi > COORD_TOP)
					z_hi = COORD_TOP;
			end

			wait_idle();
			write_reg(pcoe_pkg::REG_SPHERE_MODE, 48'(sph));
			write_reg(pcoe_pkg::REG_RADIUS_SQ, 48'(rsq));
			write_reg(pcoe_pkg::REG_INV_LENGTH, 48'(inv));
			write_reg(pcoe_pkg::REG_SWAP_PAIRS, 48'(sw));
			write_reg(pcoe_pkg::REG_WIDEN_FIRST, 48'(wf));
			write_reg(pcoe_pkg::REG_WIDEN_SECOND, 48'(ws));

			case (ph % 4)
				0: begin send_idle_pct = 0; rx_stall_pct = 0; end
				1: begin send_idle_pct = 58; rx_stall_pct = 0; end
				2: begin send_idle_pct = 0; rx_stall_pct = 58; end
				default: begin send_idle_pct = 9; rx_stall_pct = 9; end
			endcase
			run_clouds(PHASE_POINTS, xy_span, z_lo, z_hi, 25);
		end

		// Result side held off while mostly last points keep coming, so the input backs up.
		wait_idle();
		send_idle_pct = 0;
		rx_stall_pct = 0;
		hold_asked++;
		run_clouds(40, xy_span, z_lo, z_hi, 80);

		p = '{C_ZERO, C_ZERO, C_ZERO, 17'd0, 1'b1};
		send_point(p, 1'b0, '0);
		wait_idle();

		if (errors == 0 && missing == 0)
			$display("point_cloud_overlap_extents regression: pass");
		else
			$display("point_cloud_overlap_extents regression: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/pcoe_pkg.sv
hdl/pcoe_ifs.sv
hdl/pcoe_front.sv
hdl/pcoe_queue.sv
hdl/pcoe_back.sv
hdl/point_cloud_overlap_extents.sv
sim/point_cloud_overlap_extents_test.sv
